// File: src/dqs_pkg.sv
// Shared types and constants for the deque with index and search.
`timescale 1ns / 1ps

package dqs_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 8;
    localparam int OP_W      = 3;
    localparam int STAT_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ       = 3'd4,
        OP_FIND       = 3'd5
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic load;
        logic exec;
        logic fetch;
        logic scan;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic fetch_req;
        logic scan_req;
        logic scan_end;
        logic out_free;
    } t_dp_sts;

endpackage

// File: src/dqs_in_if.sv
// Input channel: opcode, value and position with valid/ready.
`timescale 1ns / 1ps

interface dqs_in_if;
    logic                                valid;
    logic                                ready;
    logic [dqs_pkg::OP_W-1:0]            opcode;
    logic signed [dqs_pkg::DATA_W-1:0]   value;
    logic [dqs_pkg::POS_W-1:0]           position;

    modport source (output valid, output opcode, output value, output position, input ready);
    modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

// File: src/dqs_out_if.sv
// Output channel: data, found position and status with valid/ready.
`timescale 1ns / 1ps

interface dqs_out_if #(
    parameter int FPOS_W = $clog2(dqs_pkg::DEPTH_DEF + 1)
);
    logic                                valid;
    logic                                ready;
    logic signed [dqs_pkg::DATA_W-1:0]   data;
    logic [FPOS_W-1:0]                   found_position;
    logic [dqs_pkg::STAT_W-1:0]          status;

    modport source (output valid, output data, output found_position, output status, input ready);
    modport sink   (input valid, input data, input found_position, input status, output ready);
endinterface

// File: src/dqs_ctrl.sv
// Controller state machine sequencing one transaction through the datapath.
`timescale 1ns / 1ps

module dqs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  dqs_pkg::t_dp_sts i_sts,
    output dqs_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    priority if (i_sts.fetch_req) begin
                        r_state <= S_FETCH;
                    end else if (i_sts.scan_req) begin
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_FETCH: begin
                    r_state <= S_DONE;
                end
                S_SCAN: begin
                    if (i_sts.scan_end) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec  = (r_state == S_EXEC);
        o_cmd.fetch = (r_state == S_FETCH);
        o_cmd.scan  = (r_state == S_SCAN);
        o_cmd.emit  = (r_state == S_DONE) && i_sts.out_free;
    end

    a_load_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_EXEC)
        else $error("accepted transaction did not enter execute");

    a_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |=> r_state == S_SCAN || r_state == S_DONE)
        else $error("scan left to an unexpected state");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && !i_sts.out_free |=> r_state == S_DONE)
        else $error("result dropped while output register busy");

endmodule

// File: src/dqs_dpath.sv
// Datapath: circular entry memory, head and count, scan counter and output register.
`timescale 1ns / 1ps

module dqs_dpath #(
    parameter int DEPTH = dqs_pkg::DEPTH_DEF,
    parameter int FPOS_W = $clog2(DEPTH + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dqs_pkg::t_dp_cmd                  i_cmd,
    output dqs_pkg::t_dp_sts                  o_sts,
    input  logic [dqs_pkg::OP_W-1:0]          i_opcode,
    input  logic signed [dqs_pkg::DATA_W-1:0] i_value,
    input  logic [dqs_pkg::POS_W-1:0]         i_position,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [dqs_pkg::DATA_W-1:0] o_data,
    output logic [FPOS_W-1:0]                 o_found_position,
    output logic [dqs_pkg::STAT_W-1:0]        o_status
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = FPOS_W;
    localparam int CMP_W  = (dqs_pkg::POS_W > CNT_W) ? dqs_pkg::POS_W : CNT_W;

    logic signed [dqs_pkg::DATA_W-1:0] r_mem [DEPTH];

    logic [ADDR_W-1:0]                 r_head;
    logic [CNT_W-1:0]                  r_count;
    dqs_pkg::t_opcode                  r_op;
    logic signed [dqs_pkg::DATA_W-1:0] r_value;
    logic [dqs_pkg::POS_W-1:0]         r_pos;
    logic [CNT_W-1:0]                  r_cmp;
    logic signed [dqs_pkg::DATA_W-1:0] r_rd_data;
    logic signed [dqs_pkg::DATA_W-1:0] r_res_data;
    logic [FPOS_W-1:0]                 r_res_fpos;
    dqs_pkg::t_status                  r_res_status;
    logic                              r_out_valid;
    logic signed [dqs_pkg::DATA_W-1:0] r_out_data;
    logic [FPOS_W-1:0]                 r_out_fpos;
    dqs_pkg::t_status                  r_out_status;

    logic              w_full;
    logic              w_empty;
    logic              w_is_push;
    logic [CMP_W-1:0]  w_k;
    logic              w_in_range;
    logic [CNT_W-1:0]  w_next_cmp;
    logic              w_match;
    logic              w_last;
    logic [ADDR_W-1:0] w_front_slot;
    logic [ADDR_W-1:0] w_pop_head;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [ADDR_W-1:0] w_rd_addr;

    function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                   input logic [ADDR_W-1:0] off);
        logic [ADDR_W:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= (ADDR_W+1)'(DEPTH)) begin
            sum = sum - (ADDR_W+1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    always_comb begin
        w_full       = (r_count == CNT_W'(DEPTH));
        w_empty      = (r_count == '0);
        w_is_push    = (r_op == dqs_pkg::OP_PUSH_BACK) || (r_op == dqs_pkg::OP_PUSH_FRONT);
        w_k          = (r_pos <= dqs_pkg::POS_W'(1)) ? '0 : CMP_W'(r_pos) - CMP_W'(1);
        w_in_range   = (w_k < CMP_W'(r_count));
        w_next_cmp   = r_cmp + CNT_W'(1);
        w_match      = (r_rd_data == r_value);
        w_last       = (w_next_cmp == r_count);
        w_front_slot = (r_head == '0) ? ADDR_W'(DEPTH - 1) : r_head - ADDR_W'(1);
        w_pop_head   = slot_of(r_head, ADDR_W'(1));
        w_wr_addr    = (r_op == dqs_pkg::OP_PUSH_FRONT) ? w_front_slot
                                                        : slot_of(r_head, r_count[ADDR_W-1:0]);
        priority if (i_cmd.scan) begin
            w_rd_addr = slot_of(r_head, w_next_cmp[ADDR_W-1:0]);
        end else if (r_op == dqs_pkg::OP_FIND) begin
            w_rd_addr = r_head;
        end else begin
            w_rd_addr = slot_of(r_head, w_k[ADDR_W-1:0]);
        end

        o_sts.fetch_req = (r_op == dqs_pkg::OP_READ) && w_in_range;
        o_sts.scan_req  = (r_op == dqs_pkg::OP_FIND) && !w_empty;
        o_sts.scan_end  = w_match || w_last;
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_is_push && !w_full) begin
            r_mem[w_wr_addr] <= r_value;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                unique case (r_op)
                    dqs_pkg::OP_PUSH_BACK: begin
                        if (!w_full) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                    dqs_pkg::OP_PUSH_FRONT: begin
                        if (!w_full) begin
                            r_head  <= w_front_slot;
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                    dqs_pkg::OP_POP_FRONT: begin
                        if (!w_empty) begin
                            r_head  <= w_pop_head;
                            r_count <= r_count - CNT_W'(1);
                        end
                    end
                    dqs_pkg::OP_POP_BACK: begin
                        if (!w_empty) begin
                            r_count <= r_count - CNT_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= dqs_pkg::t_opcode'(i_opcode);
            r_value <= i_value;
            r_pos   <= i_position;
        end
        if (i_cmd.exec) begin
            r_cmp      <= '0;
            r_res_data <= '0;
            r_res_fpos <= '0;
            unique case (r_op)
                dqs_pkg::OP_PUSH_BACK, dqs_pkg::OP_PUSH_FRONT: begin
                    r_res_status <= w_full ? dqs_pkg::ST_FULL : dqs_pkg::ST_OK;
                end
                dqs_pkg::OP_POP_FRONT, dqs_pkg::OP_POP_BACK: begin
                    r_res_status <= w_empty ? dqs_pkg::ST_EMPTY : dqs_pkg::ST_OK;
                end
                dqs_pkg::OP_READ: begin
                    r_res_status <= w_in_range ? dqs_pkg::ST_OK : dqs_pkg::ST_EMPTY;
                end
                dqs_pkg::OP_FIND: begin
                    r_res_status <= dqs_pkg::ST_EMPTY;
                end
                default: begin
                    r_res_status <= dqs_pkg::ST_OK;
                end
            endcase
        end
        if (i_cmd.fetch) begin
            r_res_data <= r_rd_data;
        end
        if (i_cmd.scan) begin
            r_cmp <= w_next_cmp;
            if (w_match) begin
                r_res_fpos   <= w_next_cmp;
                r_res_status <= dqs_pkg::ST_OK;
            end
        end
        if (i_cmd.emit) begin
            r_out_data   <= r_res_data;
            r_out_fpos   <= r_res_fpos;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_data           = r_out_data;
    assign o_found_position = r_out_fpos;
    assign o_status         = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && w_is_push && !w_full |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("accepted push did not grow the count");

    a_scan_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> r_cmp < r_count)
        else $error("scan compares past the last live entry");

endmodule

// File: src/deque_with_index_and_search_top.sv
// Top level of the bounded deque with positional read and value search.
`timescale 1ns / 1ps

// One transaction is handled at a time. Push, pop, an unused opcode and a
// read past the end go through execute to the result, an in-range
// positional read adds a fetch of the entry, and a find on a non-empty
// deque adds a scan that stops at a match or at the back, since the search
// walks the entry memory one entry per cycle through its single read port.
// The result sits in an output register; the next transaction is accepted
// once the previous result is loaded there, even if it has not been taken.
module deque_with_index_and_search_top #(
    parameter int DEPTH = dqs_pkg::DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dqs_in_if.sink     i_in,
    dqs_out_if.source  o_out
);

    localparam int FPOS_W = $clog2(DEPTH + 1);

    dqs_pkg::t_dp_cmd w_cmd;
    dqs_pkg::t_dp_sts w_sts;
    logic             w_in_ready;
    logic             w_out_valid;
    logic signed [dqs_pkg::DATA_W-1:0] w_data;
    logic [FPOS_W-1:0]                 w_fpos;
    logic [dqs_pkg::STAT_W-1:0]        w_status;

    dqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    dqs_dpath #(
        .DEPTH  (DEPTH),
        .FPOS_W (FPOS_W)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_opcode         (i_in.opcode),
        .i_value          (i_in.value),
        .i_position       (i_in.position),
        .o_out_valid      (w_out_valid),
        .i_out_ready      (o_out.ready),
        .o_data           (w_data),
        .o_found_position (w_fpos),
        .o_status         (w_status)
    );

    assign i_in.ready           = w_in_ready;
    assign o_out.valid          = w_out_valid;
    assign o_out.data           = w_data;
    assign o_out.found_position = w_fpos;
    assign o_out.status         = w_status;

endmodule
